### sv/htfd_pkg.sv
// types, constants and the crc-8 byte update of the humidity/temperature frame decoder
// no dependencies; compiled first

package htfd_pkg;

    typedef logic [7:0]         t_byte;
    typedef logic [15:0]        t_word;
    typedef logic signed [14:0] t_temp_centi;
    typedef logic [13:0]        t_hum_centi;
    typedef logic [6:0]         t_hum_pct;

    localparam t_byte       CRC_POLY     = 8'h31;
    localparam t_byte       CRC_INIT     = 8'hFF;
    localparam logic [14:0] TEMP_SPAN    = 15'd17500;
    localparam logic [15:0] TEMP_OFFSET  = 16'd4500;
    localparam logic [13:0] HUM_SPAN     = 14'd10000;
    localparam logic [6:0]  PERCENT_SPAN = 7'd100;

    // byte position inside the six-byte frame
    typedef enum logic [5:0] {
        POS_T_HI  = 6'b000001,
        POS_T_LO  = 6'b000010,
        POS_T_CRC = 6'b000100,
        POS_H_HI  = 6'b001000,
        POS_H_LO  = 6'b010000,
        POS_H_CRC = 6'b100000
    } t_pos;

    // both words of a finished frame with their check outcomes
    typedef struct packed {
        t_word temp_word;
        logic  temp_ok;
        t_word hum_word;
        logic  hum_ok;
    } t_frame;

    typedef struct packed {
        t_temp_centi temperature_centi;
        logic        temperature_ok;
        t_hum_centi  humidity_centi;
        t_hum_pct    humidity_percent;
        logic        humidity_ok;
    } t_result;

    // msb-first crc-8, no reflection, no final xor
    function automatic t_byte crc_byte_update(input t_byte crc, input t_byte b);
        t_byte c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### sv/htfd_ifs.sv
// valid/ready channel interfaces: received bytes in, decoded results out
// depends on htfd_pkg

interface htfd_byte_if;
    logic             valid;
    logic             ready;
    htfd_pkg::t_byte  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface htfd_result_if;
    logic                  valid;
    logic                  ready;
    htfd_pkg::t_temp_centi temperature_centi;
    logic                  temperature_ok;
    htfd_pkg::t_hum_centi  humidity_centi;
    htfd_pkg::t_hum_pct    humidity_percent;
    logic                  humidity_ok;

    modport source (output valid, output temperature_centi, output temperature_ok,
                    output humidity_centi, output humidity_percent, output humidity_ok,
                    input ready);
    modport sink   (input valid, input temperature_centi, input temperature_ok,
                    input humidity_centi, input humidity_percent, input humidity_ok,
                    output ready);
endinterface

### sv/humidity_temp_frame_decoder_core.sv
// top level of the humidity/temperature frame decoder: framing, crc check, result pipeline
// depends on htfd_pkg, htfd_ifs and htfd_convert

// Bytes read back from the sensor enter on i_byte, one byte per accepted
// handshake, in frame order: temperature high, low, crc, then humidity high,
// low, crc. Each two-byte value is checked with crc-8 (poly 0x31, init 0xFF)
// on its own. Every sixth byte produces one result on o_result: temperature in
// hundredths of a degree and humidity in hundredths and whole percent, each
// zeroed with its ok flag low when its crc byte did not match. A byte is taken
// every clock cycle while results drain; the crc update runs on the incoming
// byte in the same cycle it is accepted. After the last byte of a frame is
// accepted, one register holds the finished frame and a second holds the
// scaled values behind one multiply of at most 16x15 per field. The input only
// stalls when both registers are full and o_result is not ready.
// No clearing pass after reset; the frame position restarts at the first byte.

module humidity_temp_frame_decoder_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    htfd_byte_if.sink     i_byte,
    htfd_result_if.source o_result
);
    import htfd_pkg::*;

    // frame tracking state
    t_pos    r_pos,       n_pos;
    t_byte   r_crc,       n_crc;
    t_word   r_word,      n_word;
    t_word   r_temp_word, n_temp_word;
    logic    r_temp_ok,   n_temp_ok;

    // finished frame waiting for conversion
    logic    r_s1_valid;
    t_frame  r_s1;
    t_frame  w_frame;

    // result register
    logic    r_out_valid;
    t_result r_out;
    t_result w_result;

    logic    w_accept;
    logic    w_frame_done;
    logic    w_s1_adv;
    logic    w_crc_match;

    // frame slot moves on when the result register is free or being drained
    assign w_s1_adv     = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_byte.ready = !r_s1_valid || w_s1_adv;
    assign w_accept     = i_byte.valid && i_byte.ready;
    assign w_crc_match  = (r_crc == i_byte.rx_byte);

    always_comb begin
        n_pos        = r_pos;
        n_crc        = r_crc;
        n_word       = r_word;
        n_temp_word  = r_temp_word;
        n_temp_ok    = r_temp_ok;
        w_frame_done = 1'b0;
        case (r_pos)
            POS_T_LO: begin
                n_crc  = crc_byte_update(r_crc, i_byte.rx_byte);
                n_word = {r_word[15:8], i_byte.rx_byte};
                n_pos  = POS_T_CRC;
            end
            POS_H_LO: begin
                n_crc  = crc_byte_update(r_crc, i_byte.rx_byte);
                n_word = {r_word[15:8], i_byte.rx_byte};
                n_pos  = POS_H_CRC;
            end
            POS_T_CRC: begin
                n_temp_word = r_word;
                n_temp_ok   = w_crc_match;
                n_crc       = CRC_INIT;
                n_pos       = POS_H_HI;
            end
            POS_H_CRC: begin
                n_crc        = CRC_INIT;
                n_pos        = POS_T_HI;
                w_frame_done = 1'b1;
            end
            POS_H_HI: begin
                n_crc  = crc_byte_update(CRC_INIT, i_byte.rx_byte);
                n_word = {i_byte.rx_byte, 8'h00};
                n_pos  = POS_H_LO;
            end
            default: begin
                // first byte of a frame, also any stray position
                n_crc  = crc_byte_update(CRC_INIT, i_byte.rx_byte);
                n_word = {i_byte.rx_byte, 8'h00};
                n_pos  = POS_T_LO;
            end
        endcase
    end

    always_comb begin
        w_frame.temp_word = r_temp_word;
        w_frame.temp_ok   = r_temp_ok;
        w_frame.hum_word  = r_word;
        w_frame.hum_ok    = w_crc_match;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_T_HI;
        end else if (w_accept) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_crc       <= n_crc;
            r_word      <= n_word;
            r_temp_word <= n_temp_word;
            r_temp_ok   <= n_temp_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept && w_frame_done) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_frame_done) begin
            r_s1 <= w_frame;
        end
    end

    // scaling of both words
    htfd_convert u_convert (
        .i_frame  (r_s1),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out <= w_result;
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.temperature_centi = r_out.temperature_centi;
    assign o_result.temperature_ok    = r_out.temperature_ok;
    assign o_result.humidity_centi    = r_out.humidity_centi;
    assign o_result.humidity_percent  = r_out.humidity_percent;
    assign o_result.humidity_ok       = r_out.humidity_ok;

    // failed temperature check reports zero
    a_temp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.temperature_ok) |-> (o_result.temperature_centi == 15'sd0))
        else $error("temperature not zero on failed check");

    // failed humidity check reports zero in both units
    a_hum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.humidity_ok)
            |-> (o_result.humidity_centi == 14'd0 && o_result.humidity_percent == 7'd0))
        else $error("humidity not zero on failed check");

    // whole percent agrees with the hundredths value
    a_pct_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (({7'd0, o_result.humidity_percent} * 14'd100
                                <= o_result.humidity_centi)
                            && ({7'd0, o_result.humidity_percent} * 14'd100 + 14'd100
                                > o_result.humidity_centi)))
        else $error("whole percent inconsistent with hundredths");

    // last byte of a frame always fills the frame slot
    a_frame_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_pos == POS_H_CRC) |=> r_s1_valid)
        else $error("finished frame not captured");

endmodule

### sv/htfd_convert.sv
// scales the raw temperature and humidity words into hundredths and whole percent
// depends on htfd_pkg

module htfd_convert (
    input  htfd_pkg::t_frame  i_frame,
    output htfd_pkg::t_result o_result
);
    import htfd_pkg::*;

    // floor(x / 65535) for x below 2^31: x + (x >> 16) + 1, then >> 16
    function automatic logic [15:0] div_word_full(input logic [31:0] x);
        logic [32:0] s;
        s = {1'b0, x} + {17'd0, x[31:16]} + 33'd1;
        return s[31:16];
    endfunction

    logic [30:0] w_temp_prod;
    logic [29:0] w_hum_prod;
    logic [22:0] w_pct_prod;
    logic [15:0] w_temp_q;
    logic [15:0] w_hum_q;
    logic [15:0] w_pct_q;
    logic [15:0] w_temp_val;

    assign w_temp_prod = {15'd0, i_frame.temp_word} * {16'd0, TEMP_SPAN};
    assign w_hum_prod  = {14'd0, i_frame.hum_word} * {16'd0, HUM_SPAN};
    // whole percent straight from the word: nested floors collapse
    assign w_pct_prod  = {7'd0, i_frame.hum_word} * {16'd0, PERCENT_SPAN};

    assign w_temp_q = div_word_full({1'b0, w_temp_prod});
    assign w_hum_q  = div_word_full({2'b00, w_hum_prod});
    assign w_pct_q  = div_word_full({9'd0, w_pct_prod});

    assign w_temp_val = w_temp_q - TEMP_OFFSET;

    always_comb begin
        o_result.temperature_ok    = i_frame.temp_ok;
        o_result.temperature_centi = i_frame.temp_ok ? t_temp_centi'(w_temp_val[14:0])
                                                     : t_temp_centi'(0);
        o_result.humidity_ok       = i_frame.hum_ok;
        o_result.humidity_centi    = i_frame.hum_ok ? w_hum_q[13:0] : 14'd0;
        o_result.humidity_percent  = i_frame.hum_ok ? w_pct_q[6:0] : 7'd0;
    end

endmodule
